// ===== hdl/dqu_pkg.sv =====
// Shared types and constants of the double-ended queue unit.
`default_nettype none

package dqu_pkg;

    // Field widths of one input item and one result item
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 72;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic op_en;   // apply the accepted operation to the deque state
        logic rd_en;   // read front and rear entries from the store
    } dqu_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/dqu_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module dqu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dqu_datapath.sv =====
// Deque datapath: index and count registers, entry store and result fields.
`default_nettype none

module dqu_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dqu_pkg::dqu_cmd_t                 cmd,
    input  wire logic [dqu_pkg::MODE_W-1:0]        mode,
    input  wire logic signed [dqu_pkg::VALUE_W-1:0] push_value,
    output logic signed [dqu_pkg::VALUE_W-1:0]     front_value,
    output logic signed [dqu_pkg::VALUE_W-1:0]     rear_value,
    output logic                                   empty_flag,
    output logic [dqu_pkg::COUNT_W-1:0]            entry_count,
    output logic [dqu_pkg::STATUS_W-1:0]           status
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] rear_reg, rear_next;
    logic [CW-1:0] count_reg, count_next;
    logic [dqu_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [dqu_pkg::VALUE_W-1:0] rd_data_a;
    logic [dqu_pkg::VALUE_W-1:0] rd_data_b;
    logic                        full;
    logic                        empty;
    logic [CW+4:0]               count_ext;

    // Circular slot stepping
    function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] idx);
        slot_next = (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] idx);
        slot_prev = (idx == '0) ? IW'(DEPTH - 1) : idx - IW'(1);
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Next state of indices and count for the operation at hand
    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        count_next  = count_reg;
        status_next = dqu_pkg::STATUS_OK;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        case (mode)
            dqu_pkg::MODE_PUSH_FRONT, dqu_pkg::MODE_PUSH_REAR: begin
                if (full) begin
                    status_next = dqu_pkg::STATUS_OVERFLOW;
                end else if (empty) begin
                    wr_en      = 1'b1;
                    wr_addr    = front_reg;
                    rear_next  = front_reg;
                    count_next = CW'(1);
                end else if (mode == dqu_pkg::MODE_PUSH_FRONT) begin
                    wr_en      = 1'b1;
                    front_next = slot_prev(front_reg);
                    wr_addr    = front_next;
                    count_next = count_reg + CW'(1);
                end else begin
                    wr_en      = 1'b1;
                    rear_next  = slot_next(rear_reg);
                    wr_addr    = rear_next;
                    count_next = count_reg + CW'(1);
                end
            end
            dqu_pkg::MODE_POP_FRONT, dqu_pkg::MODE_POP_REAR: begin
                if (empty) begin
                    status_next = dqu_pkg::STATUS_UNDERFLOW;
                end else begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1)) begin
                        rear_next = front_reg;
                    end else if (mode == dqu_pkg::MODE_POP_FRONT) begin
                        front_next = slot_next(front_reg);
                    end else begin
                        rear_next = slot_prev(rear_reg);
                    end
                end
            end
            default: begin
                // peek and unused codes leave the state alone
                status_next = dqu_pkg::STATUS_OK;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg  <= '0;
            rear_reg   <= '0;
            count_reg  <= '0;
            status_reg <= dqu_pkg::STATUS_OK;
        end else if (cmd.op_en) begin
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Entry store
    dqu_ram #(
        .WIDTH (dqu_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (cmd.op_en & wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (push_value),
        .rd_en     (cmd.rd_en),
        .rd_addr_a (front_reg),
        .rd_addr_b (rear_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Result fields; count keeps its low bits only
    assign count_ext   = {5'b0, count_reg};
    assign entry_count = count_ext[dqu_pkg::COUNT_W-1:0];
    assign empty_flag  = empty;
    assign status      = status_reg;
    assign front_value = empty ? '0 : rd_data_a;
    assign rear_value  = empty ? '0 : rd_data_b;

endmodule

`default_nettype wire

// ===== hdl/dqu_ctrl.sv =====
// Deque controller: sequences accept, store read and result hand-off.
`default_nettype none

module dqu_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output dqu_pkg::dqu_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    // State and handshake registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tready_reg && s_tvalid) begin
                        state_reg    <= ST_READ;
                        s_tready_reg <= 1'b0;
                    end else begin
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_READ: begin
                    state_reg    <= ST_RESULT;
                    m_tvalid_reg <= 1'b1;
                end
                ST_RESULT: begin
                    if (m_tready) begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b0;
                    m_tvalid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready  = s_tready_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign cmd.op_en = s_tvalid & s_tready_reg;
    assign cmd.rd_en = (state_reg == ST_READ);

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_unit.sv =====
// Bounded deque of signed 32-bit words, one operation per input item.
// Sequence: the accepted item updates the state and writes the store, then front
// and rear are read from the entry store (registered), then the result is offered.
// A new item is accepted only after the result of the last one has been taken, as
// set by the write-then-read sequence on the single entry store.
// Reset: synchronous active-low aresetn empties the deque; the store is not cleared.
`default_nettype none

module double_ended_queue_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] mode, [34:3] push_value, [39:35] zero
    input  wire logic [dqu_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] front_value, [63:32] rear_value, [64] empty_flag,
    // [69:65] entry_count, [71:70] status
    output logic [dqu_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    dqu_pkg::dqu_cmd_t                     cmd;
    logic signed [dqu_pkg::VALUE_W-1:0]    front_value;
    logic signed [dqu_pkg::VALUE_W-1:0]    rear_value;
    logic                                  empty_flag;
    logic [dqu_pkg::COUNT_W-1:0]           entry_count;
    logic [dqu_pkg::STATUS_W-1:0]          status;

    dqu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dqu_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .mode        (s_tdata[2:0]),
        .push_value  (s_tdata[34:3]),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_flag  (empty_flag),
        .entry_count (entry_count),
        .status      (status)
    );

    assign m_tdata = {status, entry_count, empty_flag, rear_value, front_value};

    // Never ready for a new item while a result is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // An accepted item yields its result once the store read state has passed
    a_result_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready) ##1 m_tvalid)
        else $error("result not presented on time");

    // Underflow only ever reported with an empty deque
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[71:70] == dqu_pkg::STATUS_UNDERFLOW)) |-> m_tdata[64])
        else $error("underflow reported on non-empty deque");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench of the double-ended queue unit: directed and random items.
`default_nettype none

module testbench;

    localparam int unsigned DEQUE_DEPTH = 16;
    localparam int unsigned RANDOM_ITEMS = 1125;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned HOLD_AFTER = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Spare operation codes, handled by the block as peek
    localparam logic [dqu_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [dqu_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [dqu_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

    // One result item, as the block should present it
    typedef struct packed {
        logic [dqu_pkg::VALUE_W-1:0]  front_value;
        logic [dqu_pkg::VALUE_W-1:0]  rear_value;
        logic                         empty_flag;
        logic [dqu_pkg::COUNT_W-1:0]  entry_count;
        logic [dqu_pkg::STATUS_W-1:0] status;
    } deque_view_t;

    // Tracks the deque contents and holds the views still to come out
    class deque_scoreboard;
        logic [dqu_pkg::VALUE_W-1:0] slots [DEQUE_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        deque_view_t views_due [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned pending();
            return views_due.size();
        endfunction

        // Apply one accepted operation and queue the view that follows it
        function void note_input(logic [dqu_pkg::MODE_W-1:0] mode,
                                 logic [dqu_pkg::VALUE_W-1:0] value);
            deque_view_t view;
            view.status = dqu_pkg::STATUS_OK;
            case (mode)
                dqu_pkg::MODE_PUSH_FRONT, dqu_pkg::MODE_PUSH_REAR: begin
                    if (fill >= DEQUE_DEPTH) begin
                        view.status = dqu_pkg::STATUS_OVERFLOW;
                    end else if (fill == 0) begin
                        slots[head] = value;
                        tail = head;
                        fill = 1;
                    end else if (mode == dqu_pkg::MODE_PUSH_FRONT) begin
                        head = (head == 0) ? DEQUE_DEPTH - 1 : head - 1;
                        slots[head] = value;
                        fill++;
                    end else begin
                        tail = (tail + 1 >= DEQUE_DEPTH) ? 0 : tail + 1;
                        slots[tail] = value;
                        fill++;
                    end
                end
                dqu_pkg::MODE_POP_FRONT, dqu_pkg::MODE_POP_REAR: begin
                    if (fill == 0) begin
                        view.status = dqu_pkg::STATUS_UNDERFLOW;
                    end else begin
                        fill--;
                        if (fill == 0) begin
                            tail = head;
                        end else if (mode == dqu_pkg::MODE_POP_FRONT) begin
                            head = (head + 1 >= DEQUE_DEPTH) ? 0 : head + 1;
                        end else begin
                            tail = (tail == 0) ? DEQUE_DEPTH - 1 : tail - 1;
                        end
                    end
                end
                default: ;
            endcase
            // empty deque shows zeros at both ends
            if (fill == 0) begin
                view.front_value = '0;
                view.rear_value = '0;
                view.empty_flag = 1'b1;
            end else begin
                view.front_value = slots[head];
                view.rear_value = slots[tail];
                view.empty_flag = 1'b0;
            end
            view.entry_count = fill[dqu_pkg::COUNT_W-1:0];
            views_due.push_back(view);
        endfunction

        function void compare_field(string name, logic [dqu_pkg::VALUE_W-1:0] want,
                                    logic [dqu_pkg::VALUE_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one output item with the oldest view due
        function void check_result(logic [dqu_pkg::OUT_TDATA_W-1:0] data);
            deque_view_t want;
            checked++;
            if (views_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %0h", $time, data);
                return;
            end
            want = views_due.pop_front();
            compare_field("front_value", want.front_value, data[31:0]);
            compare_field("rear_value", want.rear_value, data[63:32]);
            compare_field("empty_flag", 32'(want.empty_flag), 32'(data[64]));
            compare_field("entry_count", 32'(want.entry_count), 32'(data[69:65]));
            compare_field("status", 32'(want.status), 32'(data[71:70]));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dqu_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dqu_pkg::OUT_TDATA_W-1:0] m_tdata;

    // no random idling on either side while set
    bit quiet = 1'b0;
    bit held = 1'b0;

    deque_scoreboard sb = new();

    double_ended_queue_unit #(
        .DEPTH(DEQUE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one item, with random gaps first, and wait for its acceptance
    task automatic send_item(input logic [dqu_pkg::MODE_W-1:0] mode,
                             input logic [dqu_pkg::VALUE_W-1:0] value);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(dqu_pkg::IN_TDATA_W - dqu_pkg::MODE_W - dqu_pkg::VALUE_W){1'b0}},
                    value, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(mode, value);
    endtask

    // Random operation stream; the push share drifts so the deque fills and drains
    task automatic send_random(input int unsigned count);
        int unsigned push_share;
        int unsigned pick;
        logic [dqu_pkg::MODE_W-1:0] mode;
        logic [dqu_pkg::VALUE_W-1:0] value;
        push_share = 50;
        for (int unsigned i = 0; i < count; i++) begin
            quiet = (i >= 500 && i < 700);
            if (i % 48 == 0) begin
                case ($urandom_range(0, 4))
                    0: push_share = 88;
                    1: push_share = 12;
                    2: push_share = 50;
                    3: push_share = 70;
                    default: push_share = 30;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                mode = dqu_pkg::MODE_PEEK;
            end else if (pick < 10) begin
                case ($urandom_range(0, 2))
                    0: mode = MODE_SPARE_A;
                    1: mode = MODE_SPARE_B;
                    default: mode = MODE_SPARE_C;
                endcase
            end else if ($urandom_range(0, 99) < push_share) begin
                mode = $urandom_range(0, 1) ? dqu_pkg::MODE_PUSH_FRONT
                                            : dqu_pkg::MODE_PUSH_REAR;
            end else begin
                mode = $urandom_range(0, 1) ? dqu_pkg::MODE_POP_FRONT
                                            : dqu_pkg::MODE_POP_REAR;
            end
            // mostly random words, now and then an extreme
            case ($urandom_range(0, 15))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'h0000_0000;
                3: value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            send_item(mode, value);
        end
        quiet = 1'b0;
    endtask

    // Receiver: random back-pressure and one long hold-off
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // Sample accepted results
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Stimulus and end of run
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty deque: peek, underflow at both ends, spare codes
        send_item(dqu_pkg::MODE_PEEK, 32'h0000_0000);
        send_item(dqu_pkg::MODE_POP_FRONT, 32'hFFFF_FFFF);
        send_item(dqu_pkg::MODE_POP_REAR, 32'h0000_0000);
        send_item(MODE_SPARE_A, 32'h1234_5678);
        send_item(MODE_SPARE_C, 32'hFFFF_FFFF);
        // push into empty, then remove down to empty again
        send_item(dqu_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(dqu_pkg::MODE_PUSH_REAR, 32'h8000_0000);
        send_item(dqu_pkg::MODE_POP_FRONT, 32'h0000_0000);
        send_item(dqu_pkg::MODE_POP_REAR, 32'h0000_0000);
        // fill from both ends, then overflow at both ends
        for (int i = 0; i < DEQUE_DEPTH; i++) begin
            send_item(i[0] ? dqu_pkg::MODE_PUSH_REAR : dqu_pkg::MODE_PUSH_FRONT,
                      (i == 0) ? 32'hFFFF_FFFF : {i[15:0], 16'h5A5A});
        end
        send_item(dqu_pkg::MODE_PUSH_FRONT, 32'h0BAD_F00D);
        send_item(dqu_pkg::MODE_PUSH_REAR, 32'h7FFF_FFFF);
        send_item(MODE_SPARE_B, 32'h8000_0000);

        send_random(RANDOM_ITEMS);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
